/* rtl/ibl_pkg.sv */
// Shared types and constants for the blocked-range list.
package ibl_pkg;

  localparam int PADDING_BITS   = 8;
  localparam int INTERVAL_BITS  = 10;
  localparam int PAD_BITS       = PADDING_BITS + INTERVAL_BITS;
  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [PADDING_BITS-1:0]   PADDING_RESET    = 8'd12;
  localparam logic [INTERVAL_BITS-1:0]  INTERVAL_RESET   = 10'd0;
  localparam logic [INTERVAL_BITS-1:0]  DEFAULT_FRAME_MS = 10'd41;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_PADDING_FRAMES = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_INTERVAL = 4'd1;

  typedef enum logic [1:0] {
    KIND_QUERY  = 2'd0,
    KIND_DETECT = 2'd1,
    KIND_WINDOW = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PAD_HI,
    ST_PAD_LO,
    ST_CHECK,
    ST_RD,
    ST_EV,
    ST_FIX_LO,
    ST_FIX_HI,
    ST_WRITE,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_MERGE,
    PH_QUERY
  } phase_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

endpackage

/* rtl/ibl_ram.sv */
// Generic single-port-write, registered-read RAM.
module ibl_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/ibl_alu.sv */
// Shared add/subtract unit; the top bit of a subtract is the borrow.
module ibl_alu import ibl_pkg::*; #(
  parameter int W = 48
) (
  input  alu_op_t      op,
  input  logic [W-1:0] x,
  input  logic [W-1:0] y,
  output logic [W:0]   res
);

  always_comb begin
    unique case (op)
      ALU_ADD: res = {1'b0, x} + {1'b0, y};
      ALU_SUB: res = {1'b0, x} - {1'b0, y};
    endcase
  end

endmodule

/* rtl/interval_block_list_merge_top.sv */
// Top level of the blocked-range list: sequencer, ring-buffered list memory, shared adder.
//
//  channel   | handshake                     | payload
//  ----------+-------------------------------+------------------------------------
//  command   | start, busy (taken: start&!busy) | kind, time_a, time_b
//  result    | done (one-cycle strobe)       | blocked, dropped, stored_count
//  config    | cfg_valid, cfg_ready          | cfg_index, cfg_data
//
// Ranges sit in a ring buffer (head, count) in one registered-read RAM; pruning and
// merging only ever consume the front, so an insert rewrites at most one entry.
// A query or an insert visits at most RANGE_CAPACITY entries (a detection pads the window
// first); each entry visited takes a RAM read, then a compare on the shared adder.
// busy stays high from acceptance through done.
// Reset is synchronous and empties the list; no clearing pass is needed.
// Results cannot be stalled; config writes are always taken.
module interval_block_list_merge_top import ibl_pkg::*; #(
  parameter int RANGE_CAPACITY = 16,
  parameter int TIME_BITS      = 48
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [1:0]                             kind,
  input  logic [TIME_BITS-1:0]                   time_a,
  input  logic [TIME_BITS-1:0]                   time_b,
  output logic                                   done,
  output logic                                   blocked,
  output logic                                   dropped,
  output logic [$clog2(RANGE_CAPACITY+1)-1:0]    stored_count,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]              cfg_index,
  input  logic [CFG_DATA_BITS-1:0]               cfg_data
);

  localparam int IW = RANGE_CAPACITY > 1 ? $clog2(RANGE_CAPACITY) : 1;
  localparam int CW = $clog2(RANGE_CAPACITY + 1);
  localparam int AW = TIME_BITS > PAD_BITS ? TIME_BITS : PAD_BITS;
  localparam int DW = 2 * TIME_BITS;
  localparam logic [IW-1:0] LAST_IDX = IW'(RANGE_CAPACITY - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(RANGE_CAPACITY);

  state_t state, state_next;
  phase_t phase, phase_next;

  logic [IW-1:0] head, head_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [IW-1:0] ptr, ptr_next;
  logic [CW-1:0] rem, rem_next;
  logic          is_query, is_query_next;
  logic          merged, merged_next;

  logic [TIME_BITS-1:0] win_start, win_start_next;
  logic [TIME_BITS-1:0] win_end, win_end_next;
  logic [TIME_BITS-1:0] first_start, first_start_next;
  logic [TIME_BITS-1:0] last_end, last_end_next;
  logic [PAD_BITS-1:0]  pad, pad_next;
  logic                 res_blocked, res_blocked_next;
  logic                 res_dropped, res_dropped_next;

  logic [PADDING_BITS-1:0]  padding_frames;
  logic [INTERVAL_BITS-1:0] frame_interval;
  logic [INTERVAL_BITS-1:0] frame_len;

  logic [IW-1:0] ptr_inc, ptr_dec;

  alu_op_t       alu_op;
  logic [AW-1:0] alu_x, alu_y;
  logic [AW:0]   alu_res;
  logic          borrow;

  logic          ram_we, ram_re;
  logic [DW-1:0] ram_rdata;
  logic [TIME_BITS-1:0] rd_start, rd_end;

  ibl_ram #(
    .WIDTH(DW),
    .DEPTH(RANGE_CAPACITY)
  ) u_list (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ptr_dec),
    .wdata({win_start, win_end}),
    .re   (ram_re),
    .raddr(ptr),
    .rdata(ram_rdata)
  );

  ibl_alu #(
    .W(AW)
  ) u_alu (
    .op (alu_op),
    .x  (alu_x),
    .y  (alu_y),
    .res(alu_res)
  );

  assign rd_start  = ram_rdata[DW-1 -: TIME_BITS];
  assign rd_end    = ram_rdata[TIME_BITS-1:0];
  assign borrow    = alu_res[AW];
  assign frame_len = (frame_interval == '0) ? DEFAULT_FRAME_MS : frame_interval;
  assign ptr_inc   = (ptr == LAST_IDX) ? '0 : ptr + IW'(1);
  assign ptr_dec   = (ptr == '0) ? LAST_IDX : ptr - IW'(1);

  assign busy         = (state != ST_IDLE);
  assign done         = (state == ST_DONE);
  assign blocked      = res_blocked;
  assign dropped      = res_dropped;
  assign stored_count = cnt;
  assign cfg_ready    = 1'b1;

  always_comb begin
    state_next       = state;
    phase_next       = phase;
    head_next        = head;
    cnt_next         = cnt;
    ptr_next         = ptr;
    rem_next         = rem;
    is_query_next    = is_query;
    merged_next      = merged;
    win_start_next   = win_start;
    win_end_next     = win_end;
    first_start_next = first_start;
    last_end_next    = last_end;
    pad_next         = pad;
    res_blocked_next = res_blocked;
    res_dropped_next = res_dropped;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    alu_op           = ALU_SUB;
    alu_x            = '0;
    alu_y            = '0;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          ptr_next         = head;
          rem_next         = cnt;
          phase_next       = PH_SKIP;
          merged_next      = 1'b0;
          is_query_next    = (kind_t'(kind) == KIND_QUERY);
          win_start_next   = time_a;
          win_end_next     = time_b;
          pad_next         = PAD_BITS'(padding_frames) * PAD_BITS'(frame_len);
          res_blocked_next = 1'b0;
          res_dropped_next = 1'b0;
          unique case (kind_t'(kind))
            KIND_QUERY:  state_next = ST_RD;
            KIND_DETECT: begin
              res_blocked_next = 1'b1;
              state_next       = ST_PAD_HI;
            end
            KIND_WINDOW: state_next = ST_CHECK;
            default:     state_next = ST_DONE;
          endcase
        end
      end
      ST_PAD_HI: begin
        // saturate the end at the top of the time range
        alu_op = ALU_ADD;
        alu_x  = AW'(win_start);
        alu_y  = AW'(pad);
        win_end_next = (|alu_res[AW:TIME_BITS]) ? '1 : alu_res[TIME_BITS-1:0];
        state_next   = ST_PAD_LO;
      end
      ST_PAD_LO: begin
        // clamp the start at zero
        alu_x = AW'(win_start);
        alu_y = AW'(pad);
        win_start_next = borrow ? '0 : alu_res[TIME_BITS-1:0];
        state_next     = ST_CHECK;
      end
      ST_CHECK: begin
        alu_x = AW'(win_end);
        alu_y = AW'(win_start);
        if (borrow) begin
          res_dropped_next = 1'b1;
          state_next       = ST_DONE;
        end else begin
          state_next = ST_RD;
        end
      end
      ST_RD: begin
        if (rem == '0) begin
          state_next = is_query ? ST_DONE : ST_FIX_LO;
        end else begin
          ram_re     = 1'b1;
          state_next = ST_EV;
        end
      end
      ST_EV: begin
        unique case (phase)
          PH_SKIP: begin
            // skip (or prune) ranges that end before the key
            alu_x = AW'(rd_end);
            alu_y = AW'(win_start);
            if (borrow) begin
              ptr_next   = ptr_inc;
              rem_next   = rem - CW'(1);
              state_next = ST_RD;
            end else begin
              phase_next = is_query ? PH_QUERY : PH_MERGE;
            end
          end
          PH_MERGE: begin
            alu_x = AW'(win_end);
            alu_y = AW'(rd_start);
            if (borrow) begin
              state_next = ST_FIX_LO;
            end else begin
              if (!merged) begin
                first_start_next = rd_start;
              end
              merged_next   = 1'b1;
              last_end_next = rd_end;
              ptr_next      = ptr_inc;
              rem_next      = rem - CW'(1);
              state_next    = ST_RD;
            end
          end
          PH_QUERY: begin
            alu_x = AW'(win_start);
            alu_y = AW'(rd_start);
            res_blocked_next = !borrow;
            state_next       = ST_DONE;
          end
          default: state_next = ST_DONE;
        endcase
      end
      ST_FIX_LO: begin
        if (merged) begin
          alu_x = AW'(first_start);
          alu_y = AW'(win_start);
          if (borrow) begin
            win_start_next = first_start;
          end
          state_next = ST_FIX_HI;
        end else if (rem == FULL_CNT) begin
          // no room for a new entry; keep the pruning
          res_dropped_next = 1'b1;
          head_next        = ptr;
          cnt_next         = rem;
          state_next       = ST_DONE;
        end else begin
          state_next = ST_WRITE;
        end
      end
      ST_FIX_HI: begin
        alu_x = AW'(win_end);
        alu_y = AW'(last_end);
        if (borrow) begin
          win_end_next = last_end;
        end
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        ram_we     = 1'b1;
        head_next  = ptr_dec;
        cnt_next   = rem + CW'(1);
        state_next = ST_DONE;
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      head           <= '0;
      cnt            <= '0;
      padding_frames <= PADDING_RESET;
      frame_interval <= INTERVAL_RESET;
    end else begin
      state <= state_next;
      head  <= head_next;
      cnt   <= cnt_next;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_PADDING_FRAMES) begin
          padding_frames <= cfg_data[PADDING_BITS-1:0];
        end else if (cfg_index == CFG_FRAME_INTERVAL) begin
          frame_interval <= cfg_data[INTERVAL_BITS-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    phase       <= phase_next;
    ptr         <= ptr_next;
    rem         <= rem_next;
    is_query    <= is_query_next;
    merged      <= merged_next;
    win_start   <= win_start_next;
    win_end     <= win_end_next;
    first_start <= first_start_next;
    last_end    <= last_end_next;
    pad         <= pad_next;
    res_blocked <= res_blocked_next;
    res_dropped <= res_dropped_next;
  end

endmodule

/* rtl/ibl_checker.sv */
// Port-level checks for the blocked-range list, bound to the top level.
module ibl_checker #(
  parameter int RANGE_CAPACITY = 16
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                start,
  input logic                                busy,
  input logic                                done,
  input logic [$clog2(RANGE_CAPACITY+1)-1:0] stored_count
);

  localparam int CW = $clog2(RANGE_CAPACITY + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(RANGE_CAPACITY);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy && !done)
    else $error("block not idle after result");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe outside an item");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    stored_count <= FULL_CNT)
    else $error("stored count above capacity");

  a_count_idle: assert property (@(posedge clk) disable iff (rst)
    !busy && !start |=> $stable(stored_count))
    else $error("stored count moved while idle");

endmodule

bind interval_block_list_merge_top ibl_checker #(
  .RANGE_CAPACITY(RANGE_CAPACITY)
) u_ibl_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .stored_count(stored_count)
);

/* test/range_list_watch.sv */
// Watches the blocked-range list ports, predicts each result and compares it with the block.
module range_list_watch import ibl_pkg::*; #(
  parameter int RANGE_CAPACITY = 16,
  parameter int TIME_BITS      = 48,
  localparam int COUNT_BITS    = $clog2(RANGE_CAPACITY + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      busy,
  input  logic [1:0]                kind,
  input  logic [TIME_BITS-1:0]      time_a,
  input  logic [TIME_BITS-1:0]      time_b,
  input  logic                      done,
  input  logic                      blocked,
  input  logic                      dropped,
  input  logic [COUNT_BITS-1:0]     stored_count,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output int                        fail_count,
  output int                        owed_count,
  output int                        full_hits,
  output int                        drop_hits,
  output int                        inside_hits
);

  localparam logic [TIME_BITS-1:0]     TIME_MAX         = '1;
  localparam logic [TIME_BITS-1:0]     DEFAULT_FRAME    = 41;
  localparam logic [PADDING_BITS-1:0]  PADDING_AT_RESET = 8'd12;
  localparam logic [INTERVAL_BITS-1:0] INTERVAL_AT_RESET = 10'd0;
  localparam int                       REPORT_LIMIT     = 10;

  typedef struct packed {
    logic [1:0]            kind;
    logic [TIME_BITS-1:0]  time_a;
    logic [TIME_BITS-1:0]  time_b;
    logic                  blocked;
    logic                  dropped;
    logic [COUNT_BITS-1:0] count;
  } verdict_t;

  // own copy of the sorted range list and the registers
  logic [TIME_BITS-1:0]     range_lo [RANGE_CAPACITY];
  logic [TIME_BITS-1:0]     range_hi [RANGE_CAPACITY];
  int                       range_total;
  logic [PADDING_BITS-1:0]  padding_cfg;
  logic [INTERVAL_BITS-1:0] interval_cfg;

  verdict_t range_verdicts [$];

  function automatic logic time_blocked(input logic [TIME_BITS-1:0] t);
    for (int i = 0; i < range_total; i++) begin
      if (t < range_lo[i]) return 1'b0;
      if (t <= range_hi[i]) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Returns 1 when the window ends up in the list.
  function automatic logic store_window(input logic [TIME_BITS-1:0] ws,
                                        input logic [TIME_BITS-1:0] we);
    logic [TIME_BITS-1:0] lo [RANGE_CAPACITY+1];
    logic [TIME_BITS-1:0] hi [RANGE_CAPACITY+1];
    int   drop, n, pos;
    logic joins_prev, joins_next;
    if (we < ws) return 1'b0;
    // drop ranges that end before the window opens
    drop = 0;
    while (drop < range_total && range_hi[drop] < ws) drop++;
    if (drop > 0) begin
      for (int i = drop; i < range_total; i++) begin
        range_lo[i-drop] = range_lo[i];
        range_hi[i-drop] = range_hi[i];
      end
      range_total -= drop;
    end
    n = range_total;
    pos = 0;
    while (pos < n && range_lo[pos] < ws) pos++;
    joins_prev = (pos > 0) && (range_hi[pos-1] >= ws);
    joins_next = (pos < n) && (we >= range_lo[pos]);
    // a full list keeps its pruning but refuses a new entry
    if (!joins_prev && !joins_next && n >= RANGE_CAPACITY) return 1'b0;
    for (int i = 0; i < RANGE_CAPACITY; i++) begin
      lo[i] = range_lo[i];
      hi[i] = range_hi[i];
    end
    lo[RANGE_CAPACITY] = '0;
    hi[RANGE_CAPACITY] = '0;
    if (joins_prev) begin
      if (we > hi[pos-1]) hi[pos-1] = we;
      pos--;
    end else begin
      for (int i = n; i > pos; i--) begin
        lo[i] = lo[i-1];
        hi[i] = hi[i-1];
      end
      lo[pos] = ws;
      hi[pos] = we;
      n++;
    end
    // absorb every following range that the grown entry reaches
    while (pos + 1 < n && hi[pos] >= lo[pos+1]) begin
      if (hi[pos+1] > hi[pos]) hi[pos] = hi[pos+1];
      for (int i = pos + 1; i + 1 < n; i++) begin
        lo[i] = lo[i+1];
        hi[i] = hi[i+1];
      end
      n--;
    end
    if (n > RANGE_CAPACITY) return 1'b0;
    for (int i = 0; i < RANGE_CAPACITY; i++) begin
      range_lo[i] = lo[i];
      range_hi[i] = hi[i];
    end
    range_total = n;
    return 1'b1;
  endfunction

  function automatic verdict_t step_range_list(input logic [1:0] k,
                                               input logic [TIME_BITS-1:0] a,
                                               input logic [TIME_BITS-1:0] b);
    verdict_t v;
    logic [TIME_BITS-1:0] frame_ms, pad, ws, we;
    v.kind    = k;
    v.time_a  = a;
    v.time_b  = b;
    v.blocked = 1'b0;
    v.dropped = 1'b0;
    case (k)
      KIND_QUERY: v.blocked = time_blocked(a);
      KIND_DETECT: begin
        frame_ms = {{(TIME_BITS-INTERVAL_BITS){1'b0}}, interval_cfg};
        if (interval_cfg == '0) frame_ms = DEFAULT_FRAME;
        pad = {{(TIME_BITS-PADDING_BITS){1'b0}}, padding_cfg} * frame_ms;
        // clamp the start at zero, saturate the end
        ws = (a > pad) ? a - pad : '0;
        we = (TIME_MAX - a < pad) ? TIME_MAX : a + pad;
        v.blocked = 1'b1;
        v.dropped = !store_window(ws, we);
      end
      KIND_WINDOW: v.dropped = !store_window(a, b);
      default: ;
    endcase
    v.count = range_total[COUNT_BITS-1:0];
    return v;
  endfunction

  always @(posedge clk) begin : watch_ports
    verdict_t want;
    if (rst) begin
      for (int i = 0; i < RANGE_CAPACITY; i++) begin
        range_lo[i] = '0;
        range_hi[i] = '0;
      end
      range_total  = 0;
      padding_cfg  = PADDING_AT_RESET;
      interval_cfg = INTERVAL_AT_RESET;
      range_verdicts.delete();
    end else begin
      // the result belongs to an older item, so compare before taking a new one
      if (done) begin
        if (range_verdicts.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("unexpected result: blocked=%b dropped=%b count=%0d",
                     blocked, dropped, stored_count);
        end else begin
          want = range_verdicts.pop_front();
          if (blocked !== want.blocked || dropped !== want.dropped ||
              stored_count !== want.count) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display("mismatch kind=%0d a=%h b=%h: want %b/%b/%0d got %b/%b/%0d",
                       want.kind, want.time_a, want.time_b,
                       want.blocked, want.dropped, want.count,
                       blocked, dropped, stored_count);
          end
          if (int'(want.count) == RANGE_CAPACITY) full_hits++;
          if (want.dropped) drop_hits++;
          if (want.kind == KIND_QUERY && want.blocked) inside_hits++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PADDING_FRAMES: padding_cfg  = cfg_data[PADDING_BITS-1:0];
          CFG_FRAME_INTERVAL: interval_cfg = cfg_data[INTERVAL_BITS-1:0];
          default: ;
        endcase
      end
      if (start && !busy) range_verdicts.push_back(step_range_list(kind, time_a, time_b));
    end
    owed_count = range_verdicts.size();
  end

endmodule

/* test/tb_top.sv */
// Stimulus and verdict for the blocked-range list: directed items, then random sequences.
module tb_top import ibl_pkg::*;;

  localparam int RANGE_CAPACITY = 16;
  localparam int TIME_BITS      = 48;
  localparam int COUNT_BITS     = $clog2(RANGE_CAPACITY + 1);
  localparam int PHASE_ITEMS    = 138;
  localparam int PHASES         = 9;
  localparam int DRAIN_CYCLES   = 64;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
  localparam logic [1:0]           KIND_UNUSED = 2'd3;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      start     = 1'b0;
  logic [1:0]                kind      = KIND_QUERY;
  logic [TIME_BITS-1:0]      time_a    = '0;
  logic [TIME_BITS-1:0]      time_b    = '0;
  logic                      cfg_valid = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_PADDING_FRAMES;
  logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;
  logic                      busy, done, blocked, dropped, cfg_ready;
  logic [COUNT_BITS-1:0]     stored_count;

  int fail_count, owed_count, full_hits, drop_hits, inside_hits;
  int items_sent    = 0;
  int settings_used = 1;
  bit no_idle       = 1'b0;

  interval_block_list_merge_top #(
    .RANGE_CAPACITY(RANGE_CAPACITY),
    .TIME_BITS(TIME_BITS)
  ) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .time_a(time_a), .time_b(time_b), .done(done), .blocked(blocked),
    .dropped(dropped), .stored_count(stored_count), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  range_list_watch #(
    .RANGE_CAPACITY(RANGE_CAPACITY),
    .TIME_BITS(TIME_BITS)
  ) watch (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .time_a(time_a), .time_b(time_b), .done(done), .blocked(blocked),
    .dropped(dropped), .stored_count(stored_count), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .owed_count(owed_count), .full_hits(full_hits),
    .drop_hits(drop_hits), .inside_hits(inside_hits)
  );

  always #2 clk = ~clk;

  function automatic logic [TIME_BITS-1:0] ms(input int unsigned v);
    return {{(TIME_BITS-32){1'b0}}, v};
  endfunction

  function automatic logic [TIME_BITS-1:0] rand_time();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[TIME_BITS-1:0];
  endfunction

  // Mostly real kinds, now and then the unused code.
  function automatic logic [1:0] random_kind();
    if ($urandom_range(0, 19) == 0) return KIND_UNUSED;
    return 2'($urandom_range(0, 2));
  endfunction

  function automatic logic [TIME_BITS-1:0] pick_base();
    case ($urandom_range(0, 7))
      0:       return ms($urandom_range(0, 1000));
      1:       return TIME_MAX - ms($urandom_range(0, 200000));
      default: return rand_time() >> $urandom_range(0, 40);
    endcase
  endfunction

  // Enter and leave at a falling edge; start stays high when the next item follows at once.
  task automatic send_item(input logic [1:0] k, input logic [TIME_BITS-1:0] a,
                           input logic [TIME_BITS-1:0] b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start  <= 1'b1;
    kind   <= k;
    time_a <= a;
    time_b <= b;
    do @(posedge clk); while (busy);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (owed_count != 0 || busy) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic set_padding(input int unsigned frames, input int unsigned interval);
    wait_idle();
    write_reg(CFG_PADDING_FRAMES, frames[CFG_DATA_BITS-1:0]);
    write_reg(CFG_FRAME_INTERVAL, interval[CFG_DATA_BITS-1:0]);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Descending disjoint windows fill the list without pruning, then probe around it.
  task automatic fill_burst();
    logic [TIME_BITS-1:0] base, lo;
    int n, step, len, extra;
    base  = pick_base();
    n     = $urandom_range(12, 20);
    step  = $urandom_range(2, 3000);
    for (int i = n - 1; i >= 0; i--) begin
      len = $urandom_range(0, step - 2);
      lo  = base + ms(i * step);
      send_item(KIND_WINDOW, lo, lo + ms(len));
    end
    extra = $urandom_range(3, 8);
    repeat (extra) begin
      lo = base + ms($urandom_range(0, n * step)) - ms(5000);
      send_item(random_kind(), lo, lo + ms($urandom_range(0, 2 * step)));
    end
  endtask

  task automatic local_mix();
    logic [TIME_BITS-1:0] base, lo, hi;
    int span, n;
    base = pick_base();
    span = $urandom_range(50, 6000);
    n    = $urandom_range(8, 20);
    repeat (n) begin
      lo = base + ms($urandom_range(0, span));
      hi = lo + ms($urandom_range(0, span / 4));
      if ($urandom_range(0, 19) == 0) hi = lo - ms($urandom_range(1, 50));
      send_item(random_kind(), lo, hi);
    end
  endtask

  // Rising times keep pruning the front of the list.
  task automatic advance_run();
    logic [TIME_BITS-1:0] t;
    int n;
    t = pick_base();
    n = $urandom_range(8, 20);
    repeat (n) begin
      t = t + ms($urandom_range(0, 3000));
      send_item(random_kind(), t, t + ms($urandom_range(0, 800)));
    end
  endtask

  task automatic noise_run();
    int n;
    n = $urandom_range(3, 8);
    repeat (n) send_item(random_kind(), rand_time(), rand_time());
  endtask

  task automatic random_phase(input int count);
    int phase_end;
    phase_end = items_sent + count;
    while (items_sent < phase_end) begin
      no_idle = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: fill_burst();
        4, 5, 6:    local_mix();
        7, 8:       advance_run();
        default:    noise_run();
      endcase
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset registers: 12 frames of 41 ms pad a detection by 492 ms
    send_item(KIND_QUERY,  ms(0),   TIME_MAX);
    send_item(KIND_WINDOW, ms(100), ms(200));
    send_item(KIND_QUERY,  ms(100), '0);
    send_item(KIND_QUERY,  ms(200), '0);
    send_item(KIND_QUERY,  ms(201), '0);
    send_item(KIND_QUERY,  ms(99),  '0);
    send_item(KIND_UNUSED, ms(150), ms(10));
    send_item(KIND_WINDOW, ms(300), ms(299));
    send_item(KIND_WINDOW, ms(200), ms(250));
    send_item(KIND_WINDOW, ms(0),   ms(0));
    send_item(KIND_WINDOW, ms(5000), ms(5000));
    send_item(KIND_DETECT, ms(0),   TIME_MAX);
    send_item(KIND_QUERY,  ms(492), '0);
    send_item(KIND_WINDOW, ms(0),   TIME_MAX - ms(1000));
    send_item(KIND_QUERY,  TIME_MAX, TIME_MAX);
    send_item(KIND_DETECT, TIME_MAX, '0);
    send_item(KIND_QUERY,  TIME_MAX, '0);
    send_item(KIND_QUERY,  TIME_MAX - ms(493), '0);
    send_item(KIND_WINDOW, TIME_MAX, TIME_MAX);
    send_item(KIND_WINDOW, TIME_MAX, ms(0));
    send_item(KIND_DETECT, {1'b1, {(TIME_BITS-1){1'b0}}}, TIME_MAX);
    send_item(KIND_UNUSED, TIME_MAX, '0);
    send_item(KIND_QUERY,  rand_time(), rand_time());
    fill_burst();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       set_padding(0, 0);
        1:       set_padding(255, 1000);
        2:       set_padding(1, 1);
        3:       set_padding(255, 0);
        4:       set_padding(0, 1000);
        5:       set_padding(255, 1023);
        default: set_padding($urandom_range(0, 255), $urandom_range(0, 1000));
      endcase
      random_phase(PHASE_ITEMS);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("%0d items under %0d register settings, %0d queries inside a range",
             items_sent, settings_used, inside_hits);
    $display("%0d windows dropped, %0d results with the list full, %0d results missing",
             drop_hits, full_hits, owed_count);
    if (fail_count == 0 && owed_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
